// ===== hw/rtl/rxrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rxrf_pkg
// Shared constants and controller/datapath interface types for the receive
// ring FIFO.
// ----------------------------------------------------------------------------
package rxrf_pkg;

   // ring geometry: one slot stays free, so the ring holds DEPTH-1 bytes
   localparam int DEPTH = 64;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int THR_W = 7;
   localparam int CNT_W = 7;

   // clamp value for the threshold register
   localparam logic [THR_W-1:0] THR_MAX = THR_W'(DEPTH);
   localparam logic [PTR_W-1:0] LEVEL_FULL = PTR_W'(DEPTH - 1);

   // item kinds
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_PULL = 1'b1;

   // register indexes (word address bit 2)
   localparam logic CSR_ENABLE    = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic push_op;     // store byte (if enabled and not full) and give the push result
      logic empty_rsp;   // give one result with no data
      logic pull_load;   // load the pull count
      logic pull_issue;  // read one byte and give its result
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pull_none;   // pull would take no bytes
      logic last_issue;  // the next issued byte is the final one
   } ctrl_status_type;

endpackage

// ===== hw/rtl/rxrf_csr.sv =====
// ----------------------------------------------------------------------------
// rxrf_csr
// APB-style register file: enable and threshold.
// ----------------------------------------------------------------------------
module rxrf_csr import rxrf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic             enable,
   output logic [THR_W-1:0] threshold
);

   logic             enable_ff;
   logic [THR_W-1:0] threshold_ff;
   logic             wr_en;

   // registers are word aligned; the low address bits are ignored
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   // write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         threshold_ff <= '0;
      end else if (wr_en) begin
         case (paddr[2])
            CSR_ENABLE:    enable_ff    <= pwdata[0];
            CSR_THRESHOLD: threshold_ff <= pwdata[THR_W-1:0];
            default:       enable_ff    <= enable_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      prdata = '0;
      case (paddr[2])
         CSR_ENABLE:    prdata[0]         = enable_ff;
         CSR_THRESHOLD: prdata[THR_W-1:0] = threshold_ff;
         default:       prdata            = '0;
      endcase
   end

   assign enable    = enable_ff;
   assign threshold = threshold_ff;

endmodule

// ===== hw/rtl/rxrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rxrf_ctrl
// Controller: takes items and sequences the byte reads of a pull.
// ----------------------------------------------------------------------------
module rxrf_ctrl import rxrf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            kind,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            busy
);

   typedef enum logic {
      ST_IDLE,
      ST_PULL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take;

   assign take = start & (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);

   // decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (kind == KIND_PUSH) begin
                  cmd.push_op = 1'b1;
               end else if (status.pull_none) begin
                  cmd.empty_rsp = 1'b1;
               end else begin
                  cmd.pull_load = 1'b1;
                  state_in      = ST_PULL;
               end
            end
         end
         ST_PULL: begin
            cmd.pull_issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/rxrf_datapath.sv =====
// ----------------------------------------------------------------------------
// rxrf_datapath
// Ring pointers, byte memory, pull counter and result registers.
// ----------------------------------------------------------------------------
module rxrf_datapath import rxrf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_cmd_type     cmd,
   output ctrl_status_type  status,
   input  logic             enable,
   input  logic [THR_W-1:0] threshold,
   input  logic [7:0]       rx_byte,
   input  logic [CNT_W-1:0] pull_count,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_data,
   output logic             rsp_data_valid,
   output logic             rsp_last,
   output logic [5:0]       rsp_fill_level,
   output logic             rsp_threshold_hit,
   output logic             rsp_overflow
);

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] cnt_ff;

   logic             strobe_ff;
   logic             dv_ff;
   logic             last_ff;
   logic [PTR_W-1:0] level_ff;
   logic             hit_ff;
   logic             ovf_ff;

   logic [PTR_W-1:0] level;
   logic [PTR_W-1:0] pull_n;
   logic             full;
   logic             do_write;
   logic [PTR_W-1:0] push_level;
   logic [THR_W-1:0] thr_lim;
   logic             push_hit;

   // current fill level; the ring wraps at a power of two
   assign level = wr_ptr_ff - rd_ptr_ff;
   assign full  = (level == LEVEL_FULL);

   // bytes a pull takes: the smaller of the request and the level
   assign pull_n = (pull_count > {1'b0, level}) ? level : pull_count[PTR_W-1:0];

   assign status.pull_none  = (pull_n == '0);
   assign status.last_issue = (cnt_ff == PTR_W'(1));

   // push: store when enabled and not full, then check the clamped threshold
   assign do_write   = cmd.push_op & enable & ~full;
   assign push_level = do_write ? (level + PTR_W'(1)) : level;
   assign thr_lim    = (threshold > THR_MAX) ? THR_MAX : threshold;
   assign push_hit   = enable & (thr_lim != '0) & ({1'b0, push_level} >= thr_lim);

   // byte memory: one write port, registered read at the read pointer
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_ptr_ff] <= rx_byte;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   // advance pointers and the pull counter
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_write) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (cmd.pull_load) begin
            cnt_ff <= pull_n;
         end else if (cmd.pull_issue) begin
            cnt_ff    <= cnt_ff - PTR_W'(1);
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.push_op | cmd.empty_rsp | cmd.pull_issue;
      end
   end

   // result fields; the pulled byte arrives from the memory read register
   always_ff @(posedge clock) begin
      dv_ff    <= cmd.pull_issue;
      last_ff  <= cmd.push_op | cmd.empty_rsp | (cmd.pull_issue & status.last_issue);
      hit_ff   <= cmd.push_op & push_hit;
      ovf_ff   <= cmd.push_op & enable & full;
      if (cmd.push_op) begin
         level_ff <= push_level;
      end else if (cmd.pull_issue) begin
         level_ff <= level - PTR_W'(1);
      end else begin
         level_ff <= level;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_data          = dv_ff ? rd_data_ff : 8'h00;
   assign rsp_data_valid    = dv_ff;
   assign rsp_last          = last_ff;
   assign rsp_fill_level    = level_ff;
   assign rsp_threshold_hit = hit_ff;
   assign rsp_overflow      = ovf_ff;

endmodule

// ===== hw/rtl/rx_ring_fifo_with_threshold.sv =====
// ----------------------------------------------------------------------------
// rx_ring_fifo_with_threshold
// Receive ring FIFO of 64 slots (63 usable) with a fill threshold flag.
// ----------------------------------------------------------------------------
// A push item gives one result in the cycle after start; busy stays low, so
// the next item may follow at once. A pull item of n bytes (n = smaller of
// pull_count and the fill level) loads its byte count as it is taken, then
// holds busy high while the controller reads one byte a cycle from the byte
// memory; its results come out one per cycle once the first read has passed
// through the pull state and the result registers, the final one marked by
// rsp_last. A pull that takes no bytes gives one result without data in the
// cycle after start. Every result is shown for exactly one cycle with
// rsp_strobe high and cannot be held off, so the receiver must take it then.
// Registers: enable at address 0, threshold at address 4.
// ----------------------------------------------------------------------------
module rx_ring_fifo_with_threshold import rxrf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // item channel
   input  logic             start,
   output logic             busy,
   input  logic             req_kind,
   input  logic [7:0]       req_rx_byte,
   input  logic [CNT_W-1:0] req_pull_count,
   // result channel
   output logic             rsp_strobe,
   output logic [7:0]       rsp_data,
   output logic             rsp_data_valid,
   output logic             rsp_last,
   output logic [5:0]       rsp_fill_level,
   output logic             rsp_threshold_hit,
   output logic             rsp_overflow,
   // register port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   ctrl_cmd_type     cmd;
   ctrl_status_type  status;
   logic             enable;
   logic [THR_W-1:0] threshold;

   rxrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .enable    (enable),
      .threshold (threshold)
   );

   rxrf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .kind   (req_kind),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   rxrf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .enable            (enable),
      .threshold         (threshold),
      .rx_byte           (req_rx_byte),
      .pull_count        (req_pull_count),
      .rsp_strobe        (rsp_strobe),
      .rsp_data          (rsp_data),
      .rsp_data_valid    (rsp_data_valid),
      .rsp_last          (rsp_last),
      .rsp_fill_level    (rsp_fill_level),
      .rsp_threshold_hit (rsp_threshold_hit),
      .rsp_overflow      (rsp_overflow)
   );

endmodule
